/* src/ltc_pkg.sv */
package ltc_pkg;

    // Command codes carried in the cmd field of an input item.
    localparam logic [1:0] CMD_NEXT = 2'd0;
    localparam logic [1:0] CMD_PREV = 2'd1;
    localparam logic [1:0] CMD_LOAD = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FRAME_RATE = 2'd0;
    localparam logic [1:0] REG_COLOR_FLAG = 2'd1;
    localparam logic [1:0] REG_CLOCK_FLAG = 2'd2;
    localparam logic [1:0] REG_DROP_FLAG  = 2'd3;

    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [4:0]  FRAME_RATE_RESET = 5'd25;
    localparam logic [4:0]  PARITY_HIGH_RATE = 5'd25;
    localparam logic [15:0] SYNC_WORD        = 16'hBFFC;
    localparam logic [5:0]  LAST_SECOND      = 6'd59;
    localparam logic [5:0]  LAST_MINUTE      = 6'd59;
    localparam logic [4:0]  LAST_HOUR        = 5'd23;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] load_frames;
        logic [5:0] load_seconds;
        logic [5:0] load_minutes;
        logic [4:0] load_hours;
    } t_in_item;

    typedef struct packed {
        logic [63:0] frame_low;
        logic [15:0] frame_high;
        logic [4:0]  out_frames;
        logic [5:0]  out_seconds;
        logic [5:0]  out_minutes;
        logic [4:0]  out_hours;
    } t_out_item;

    // Binary to two BCD digits for values below 64: {tens[2:0], units[3:0]}.
    function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
        logic [2:0] t;
        logic [5:0] r;
        if (v >= 6'd60) begin
            t = 3'd6;
        end else if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        // Ten times the tens digit is eight times plus two times.
        r = v - {t, 3'b000} - {2'b00, t, 1'b0};
        return {t, r[3:0]};
    endfunction

endpackage

/* src/ltc_timecode_frame_generator.sv */
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one item per cycle unless stalled; the time counter and the frame encoder
// are a single combinational pass between the counter registers and the output register.
// Reset (synchronous, active low) clears the time to 00:00:00:00, empties the
// output register and restores the registers to rate 25, color 1, clock 0, drop 0.
module ltc_timecode_frame_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [ltc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ltc_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ltc_pkg::t_out_item              o_out_data
);
    import ltc_pkg::*;

    // Configuration registers.
    logic [4:0] r_frame_rate;
    logic       r_color_flag;
    logic       r_clock_flag;
    logic       r_drop_flag;

    // Time counter.
    logic [4:0] r_frames;
    logic [5:0] r_seconds;
    logic [5:0] r_minutes;
    logic [4:0] r_hours;
    logic [4:0] n_frames;
    logic [5:0] n_seconds;
    logic [5:0] n_minutes;
    logic [4:0] n_hours;

    // Output register.
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  n_out_data;

    logic       in_xfer;
    logic [4:0] frame_dec;
    logic [63:0] low;
    logic [6:0] bcd_f;
    logic [6:0] bcd_s;
    logic [6:0] bcd_m;
    logic [6:0] bcd_h;
    logic       parity;

    // The output register can take a new result whenever it is empty or its
    // current result leaves in this same cycle, so items flow back to back.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= FRAME_RATE_RESET;
            r_color_flag <= 1'b1;
            r_clock_flag <= 1'b0;
            r_drop_flag  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_RATE: r_frame_rate <= i_cfg_data[4:0];
                REG_COLOR_FLAG: r_color_flag <= i_cfg_data[0];
                REG_CLOCK_FLAG: r_clock_flag <= i_cfg_data[0];
                REG_DROP_FLAG:  r_drop_flag  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next time. A backward step from a nonzero frame still clamps to zero
    // when the rate was lowered below the current frame.
    assign frame_dec = r_frames - 5'd1;

    always_comb begin
        n_frames  = r_frames;
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        case (i_in_data.cmd)
            CMD_NEXT: begin
                if (({1'b0, r_frames} + 6'd1) < {1'b0, r_frame_rate}) begin
                    n_frames = r_frames + 5'd1;
                end else begin
                    n_frames = 5'd0;
                    if (r_seconds < LAST_SECOND) begin
                        n_seconds = r_seconds + 6'd1;
                    end else begin
                        n_seconds = 6'd0;
                        if (r_minutes < LAST_MINUTE) begin
                            n_minutes = r_minutes + 6'd1;
                        end else begin
                            n_minutes = 6'd0;
                            n_hours   = (r_hours < LAST_HOUR) ? r_hours + 5'd1 : 5'd0;
                        end
                    end
                end
            end
            CMD_PREV: begin
                if (r_frames != 5'd0) begin
                    n_frames = (frame_dec < r_frame_rate) ? frame_dec : 5'd0;
                end else begin
                    // Last frame of the second; a zero rate keeps frame zero.
                    n_frames = (r_frame_rate == 5'd0) ? 5'd0 : r_frame_rate - 5'd1;
                    if (r_seconds != 6'd0) begin
                        n_seconds = r_seconds - 6'd1;
                    end else begin
                        n_seconds = LAST_SECOND;
                        if (r_minutes != 6'd0) begin
                            n_minutes = r_minutes - 6'd1;
                        end else begin
                            n_minutes = LAST_MINUTE;
                            n_hours   = (r_hours != 5'd0) ? r_hours - 5'd1 : LAST_HOUR;
                        end
                    end
                end
            end
            CMD_LOAD: begin
                // Any out of range field loads as zero.
                n_frames  = (i_in_data.load_frames < {1'b0, r_frame_rate}) ?
                            i_in_data.load_frames[4:0] : 5'd0;
                n_seconds = (i_in_data.load_seconds < 6'd60) ? i_in_data.load_seconds : 6'd0;
                n_minutes = (i_in_data.load_minutes < 6'd60) ? i_in_data.load_minutes : 6'd0;
                n_hours   = (i_in_data.load_hours < 5'd24) ? i_in_data.load_hours : 5'd0;
            end
            default: ;  // The unused code leaves the time alone.
        endcase
    end

    // Frame assembly from the new time.
    assign bcd_f = bin_to_bcd({1'b0, n_frames});
    assign bcd_s = bin_to_bcd(n_seconds);
    assign bcd_m = bin_to_bcd(n_minutes);
    assign bcd_h = bin_to_bcd({1'b0, n_hours});

    always_comb begin
        low        = '0;
        low[3:0]   = bcd_f[3:0];
        low[9:8]   = bcd_f[5:4];
        low[10]    = r_drop_flag;
        low[11]    = r_color_flag;
        low[19:16] = bcd_s[3:0];
        low[26:24] = bcd_s[6:4];
        low[35:32] = bcd_m[3:0];
        low[42:40] = bcd_m[6:4];
        low[51:48] = bcd_h[3:0];
        low[57:56] = bcd_h[5:4];
        low[58]    = r_clock_flag;
        // The sync word carries an odd number of ones, so the parity bit is
        // set exactly when the rest of the low word holds an even number.
        parity = ~(^low);
        if (r_frame_rate == PARITY_HIGH_RATE) begin
            low[59] = parity;
        end else begin
            low[27] = parity;
        end
    end

    always_comb begin
        n_out_data.frame_low   = low;
        n_out_data.frame_high  = SYNC_WORD;
        n_out_data.out_frames  = n_frames;
        n_out_data.out_seconds = n_seconds;
        n_out_data.out_minutes = n_minutes;
        n_out_data.out_hours   = n_hours;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= 5'd0;
            r_seconds   <= 6'd0;
            r_minutes   <= 6'd0;
            r_hours     <= 5'd0;
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_frames    <= n_frames;
            r_seconds   <= n_seconds;
            r_minutes   <= n_minutes;
            r_hours     <= n_hours;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/ltc_checker.sv */
module ltc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [1:0]                      i_cfg_idx,
    input logic [ltc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input ltc_pkg::t_in_item               i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input ltc_pkg::t_out_item              o_out_data
);
    import ltc_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Every input transfer leaves a result waiting in the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("input transfer produced no result");

    // The whole frame always holds an even number of ones.
    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((^o_out_data.frame_low) ^ (^o_out_data.frame_high)) == 1'b0)
        else $error("frame parity is odd");

    // Sync word is fixed.
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.frame_high == SYNC_WORD)
        else $error("bad sync word");

    // Seconds, minutes and hours never leave their ranges.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_seconds < 6'd60) && (o_out_data.out_minutes < 6'd60)
                        && (o_out_data.out_hours < 5'd24))
        else $error("time field out of range");

endmodule

bind ltc_timecode_frame_generator ltc_checker u_ltc_checker (.*);

/* tb/tb_ltc_timecode_frame_generator.sv */
module tb_ltc_timecode_frame_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import ltc_pkg::*;

    // The command code that the block does not define; it must leave the time alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles without any transfer or register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 130;

    // Every input of the block has a known value from time zero.
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_idx   = REG_FRAME_RATE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // Our own copy of the time counter and of the registers, starting at the reset values.
    logic [4:0] tc_frame  = 5'd0;
    logic [5:0] tc_sec    = 6'd0;
    logic [5:0] tc_min    = 6'd0;
    logic [4:0] tc_hour   = 5'd0;
    logic [4:0] rate      = FRAME_RATE_RESET;
    logic       color_bit = 1'b1;
    logic       clock_bit = 1'b0;
    logic       drop_bit  = 1'b0;

    // Frames predicted for accepted input transfers, oldest first.
    t_out_item pending_frames[$];
    t_out_item want;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    // When set, neither side inserts gaps or stalls.
    bit        quiet       = 1'b0;

    ltc_timecode_frame_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    // A frame value that is not below the current rate collapses to zero.
    function automatic logic [4:0] fit_frame(input int f);
        return (f < int'(rate)) ? 5'(f) : 5'd0;
    endfunction

    // Applies one command to the time counter and builds the LTC frame that follows it.
    function automatic t_out_item advance_and_encode(input t_in_item it);
        t_out_item   r;
        logic [63:0] low;
        case (it.cmd)
            CMD_NEXT: begin
                if (int'(tc_frame) + 1 < int'(rate)) begin
                    tc_frame = fit_frame(int'(tc_frame) + 1);
                end else begin
                    tc_frame = 5'd0;
                    if (tc_sec < LAST_SECOND) begin
                        tc_sec = tc_sec + 6'd1;
                    end else begin
                        tc_sec = 6'd0;
                        if (tc_min < LAST_MINUTE) begin
                            tc_min = tc_min + 6'd1;
                        end else begin
                            tc_min = 6'd0;
                            tc_hour = (tc_hour < LAST_HOUR) ? tc_hour + 5'd1 : 5'd0;
                        end
                    end
                end
            end
            CMD_PREV: begin
                if (tc_frame != 5'd0) begin
                    tc_frame = fit_frame(int'(tc_frame) - 1);
                end else begin
                    // Borrow: the frame goes to the last one of the second.
                    tc_frame = (rate == 5'd0) ? 5'd0 : fit_frame(int'(rate) - 1);
                    if (tc_sec != 6'd0) begin
                        tc_sec = tc_sec - 6'd1;
                    end else begin
                        tc_sec = LAST_SECOND;
                        if (tc_min != 6'd0) begin
                            tc_min = tc_min - 6'd1;
                        end else begin
                            tc_min = LAST_MINUTE;
                            tc_hour = (tc_hour != 5'd0) ? tc_hour - 5'd1 : LAST_HOUR;
                        end
                    end
                end
            end
            CMD_LOAD: begin
                tc_frame = fit_frame(int'(it.load_frames));
                tc_sec   = (it.load_seconds < 6'd60) ? it.load_seconds : 6'd0;
                tc_min   = (it.load_minutes < 6'd60) ? it.load_minutes : 6'd0;
                tc_hour  = (it.load_hours < 5'd24) ? it.load_hours : 5'd0;
            end
            default: begin
            end
        endcase

        // BCD digits and flags; the user bits stay zero.
        low        = '0;
        low[3:0]   = 4'(tc_frame % 10);
        low[9:8]   = 2'(tc_frame / 10);
        low[10]    = drop_bit;
        low[11]    = color_bit;
        low[19:16] = 4'(tc_sec % 10);
        low[26:24] = 3'(tc_sec / 10);
        low[35:32] = 4'(tc_min % 10);
        low[42:40] = 3'(tc_min / 10);
        low[51:48] = 4'(tc_hour % 10);
        low[57:56] = 2'(tc_hour / 10);
        low[58]    = clock_bit;
        // Even parity over all 80 bits; its position depends on whether the rate is 25.
        if ((($countones(low) + $countones(SYNC_WORD)) % 2) != 0) begin
            if (rate == PARITY_HIGH_RATE) begin
                low[59] = 1'b1;
            end else begin
                low[27] = 1'b1;
            end
        end

        r.frame_low   = low;
        r.frame_high  = SYNC_WORD;
        r.out_frames  = tc_frame;
        r.out_seconds = tc_sec;
        r.out_minutes = tc_min;
        r.out_hours   = tc_hour;
        return r;
    endfunction

    // Sampling at the rising edge sees the values that the block saw at that edge,
    // because all stimulus is driven with nonblocking assignments. The output check
    // runs before the input prediction; since results pass through the output register,
    // a result can never belong to an item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] result with nothing expected: low %h high %h",
                                 $realtime, out_data.frame_low, out_data.frame_high);
                    end
                end else begin
                    want = pending_frames.pop_front();
                    if (out_data !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] frame_low exp %h got %h, frame_high exp %h got %h",
                                     $realtime, want.frame_low, out_data.frame_low,
                                     want.frame_high, out_data.frame_high);
                            $display("    time exp %0d:%0d:%0d:%0d got %0d:%0d:%0d:%0d",
                                     want.out_hours, want.out_minutes, want.out_seconds,
                                     want.out_frames, out_data.out_hours,
                                     out_data.out_minutes, out_data.out_seconds,
                                     out_data.out_frames);
                        end
                    end
                end
            end
            // Register writes only happen while the block is idle, so they can be
            // applied here without regard to the transfers in flight.
            if (cfg_we) begin
                case (cfg_idx)
                    REG_FRAME_RATE: rate      = cfg_data[4:0];
                    REG_COLOR_FLAG: color_bit = cfg_data[0];
                    REG_CLOCK_FLAG: clock_bit = cfg_data[0];
                    REG_DROP_FLAG:  drop_bit  = cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (in_valid && !in_stall) begin
                pending_frames.push_back(advance_and_encode(in_data));
            end
            if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // The receiver stalls about 8 times in a hundred unless a quiet stretch is on.
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 8);
        end
    end

    // A hung handshake ends the run instead of letting it spin forever.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("ltc_timecode_frame_generator regression: fail");
        $finish;
    end

    function automatic t_in_item make_item(input logic [1:0] cmd, input int f, input int s,
                                           input int m, input int h);
        t_in_item it;
        it.cmd          = cmd;
        it.load_frames  = 6'(f);
        it.load_seconds = 6'(s);
        it.load_minutes = 6'(m);
        it.load_hours   = 5'(h);
        return it;
    endfunction

    // Zero, the top of the range or anything in between, to provoke carries and borrows.
    function automatic int boundary_value(input int hi);
        case ($urandom_range(2))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    // Mostly steps, with loads that land near the wrap points, some fully random loads
    // (out of range included) and the occasional unused command.
    function automatic t_in_item random_item();
        t_in_item    it;
        logic [31:0] raw;
        int          pick;
        raw  = $urandom;
        it   = raw[$bits(t_in_item)-1:0];
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.cmd = CMD_NEXT;
        end else if (pick < 75) begin
            it.cmd = CMD_PREV;
        end else if (pick < 95) begin
            it.cmd = CMD_LOAD;
            if (pick < 88) begin
                it.load_frames  = (rate == 5'd0) ? 6'd0 : 6'(boundary_value(int'(rate) - 1));
                it.load_seconds = 6'(boundary_value(59));
                it.load_minutes = 6'(boundary_value(59));
                it.load_hours   = 5'(boundary_value(23));
            end
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid stays high
    // afterwards so that back-to-back items go out without a gap.
    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Stops offering items and waits until every predicted frame has come out and the
    // output register has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Reset values, a step each way, the backward wrap at midnight and the full
    // forward carry back to midnight.
    task automatic test_reset_and_wrap();
        send_item(make_item(CMD_UNUSED, 7, 7, 7, 7));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        send_item(make_item(CMD_PREV, 63, 63, 63, 31));
        send_item(make_item(CMD_PREV, 0, 0, 0, 0));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
    endtask

    // Loads at the top of every range, just past it and at the field maxima.
    task automatic test_load_limits();
        send_item(make_item(CMD_LOAD, 24, 59, 59, 23));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        send_item(make_item(CMD_LOAD, 63, 63, 63, 31));
        send_item(make_item(CMD_LOAD, 25, 60, 60, 24));
        send_item(make_item(CMD_LOAD, 0, 0, 0, 0));
        send_item(make_item(CMD_PREV, 0, 0, 0, 0));
    endtask

    // Rate extremes, and a rate lowered beneath the current frame.
    task automatic test_rate_changes();
        write_reg(REG_FRAME_RATE, 30);
        send_item(make_item(CMD_LOAD, 29, 59, 59, 23));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        send_item(make_item(CMD_PREV, 0, 0, 0, 0));
        // The frame sits at 29 now; it must be kept and shown under the lower rate.
        write_reg(REG_FRAME_RATE, 24);
        send_item(make_item(CMD_UNUSED, 0, 0, 0, 0));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        // With a rate of zero every frame value collapses to zero.
        write_reg(REG_FRAME_RATE, 0);
        send_item(make_item(CMD_LOAD, 5, 10, 20, 3));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        send_item(make_item(CMD_PREV, 0, 0, 0, 0));
        send_item(make_item(CMD_PREV, 0, 0, 0, 0));
        write_reg(REG_FRAME_RATE, 31);
        send_item(make_item(CMD_LOAD, 30, 0, 0, 0));
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
        write_reg(REG_FRAME_RATE, 1);
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
    endtask

    // Each flag flipped away from its reset value and back.
    task automatic test_flag_bits();
        write_reg(REG_COLOR_FLAG, 0);
        write_reg(REG_CLOCK_FLAG, 1);
        write_reg(REG_DROP_FLAG, 1);
        send_item(make_item(CMD_UNUSED, 0, 0, 0, 0));
        write_reg(REG_COLOR_FLAG, 1);
        write_reg(REG_CLOCK_FLAG, 0);
        write_reg(REG_DROP_FLAG, 0);
        send_item(make_item(CMD_NEXT, 0, 0, 0, 0));
    endtask

    // Phases of random traffic, each under its own register setting; one phase runs
    // with no gaps and no stalls at all.
    task automatic test_random_traffic();
        int new_rate;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(9))
                0:       new_rate = 0;
                1:       new_rate = 31;
                2:       new_rate = 1;
                3:       new_rate = 25;
                default: new_rate = $urandom_range(24, 30);
            endcase
            write_reg(REG_FRAME_RATE, new_rate);
            write_reg(REG_COLOR_FLAG, $urandom_range(1));
            write_reg(REG_CLOCK_FLAG, $urandom_range(1));
            write_reg(REG_DROP_FLAG, $urandom_range(1));
            quiet = (phase == PHASES / 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item());
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_and_wrap();
        test_load_limits();
        test_rate_changes();
        test_flag_bits();
        test_random_traffic();
        settle();
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("ltc_timecode_frame_generator regression: pass");
        end else begin
            $display("ltc_timecode_frame_generator regression: fail");
        end
        $finish;
    end

endmodule
